// ===== rtl/core/assert_macros.svh =====
// Assertion helpers; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SKF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SKF_ASSERT(lbl, prop, msg) `SKF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define SKF_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define SKF_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/skf_pkg.sv =====
package skf_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_F_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_NOISE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R_NOISE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_VAR = 3'd6;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // one request to the shared multiply-add unit
  typedef struct packed {
    logic               valid;
    logic               sub;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } mac_req_t;

endpackage

// ===== rtl/core/skf_req_if.sv =====
interface skf_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measurement;
  logic signed [31:0] control_input;
  logic               restart;

  modport source (output valid, output measurement, output control_input, output restart,
                  input ready);
  modport sink (input valid, input measurement, input control_input, input restart,
                output ready);
endinterface

// ===== rtl/core/skf_rsp_if.sv =====
interface skf_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] estimate;
  logic signed [31:0] innovation;
  logic        [30:0] error_variance;

  modport source (output valid, output estimate, output innovation, output error_variance,
                  input ready);
  modport sink (input valid, input estimate, input innovation, input error_variance,
                output ready);
endinterface

// ===== rtl/core/skf_mac.sv =====
`include "assert_macros.svh"

// sum = addend +/- ((a * b) >>> FRAC_BITS), product and sum registered, one op in flight
module skf_mac import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned ACC_W = 65 - FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_req_t                req_i,
  input  logic signed [ACC_W-1:0] addend_i,
  output logic                    valid_o,
  output logic signed [ACC_W-1:0] sum_o,
  output logic signed [31:0]      sat_o
);

  localparam logic signed [ACC_W-1:0] MAX_W = ACC_W'(S32_MAX);
  localparam logic signed [ACC_W-1:0] MIN_W = ACC_W'(S32_MIN);

  logic                    v1_q, v2_q;
  logic signed [63:0]      prod_q;
  logic signed [ACC_W-1:0] c_q;
  logic                    sub_q;
  logic signed [ACC_W-1:0] sum_q;
  logic signed [63:0]      sh64;
  logic signed [ACC_W-1:0] sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  // floor shift, the product fits in 64 - FRAC_BITS bits after it
  assign sh64 = prod_q >>> FRAC_BITS;
  assign sh   = sh64[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_q <= req_i.a * req_i.b;
      c_q    <= addend_i;
      sub_q  <= req_i.sub;
    end
    if (v1_q) begin
      sum_q <= sub_q ? (c_q - sh) : (c_q + sh);
    end
  end

  always_comb begin
    if (sum_q > MAX_W) begin
      sat_o = S32_MAX;
    end else if (sum_q < MIN_W) begin
      sat_o = S32_MIN;
    end else begin
      sat_o = sum_q[31:0];
    end
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

  `SKF_ASSERT(a_mac_single, req_i.valid |-> !v1_q && !v2_q, "mac: request while busy")
  `SKF_ASSERT(a_mac_latency, req_i.valid |=> ##1 valid_o, "mac: result not after two cycles")
  `SKF_ASSERT(a_mac_origin, valid_o |-> $past(req_i.valid, 2), "mac: result without request")

endmodule

// ===== rtl/core/skf_div.sv =====
`include "assert_macros.svh"

// (num << FRAC_BITS) / den, truncated toward zero and saturated to 32 bits.
// Restoring, one quotient bit per cycle; 0 when den is 0.
module skf_div import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NW = 32 + FRAC_BITS,
  localparam int unsigned CW = $clog2(NW + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  logic               busy_q, fin_q, done_q;
  logic [CW-1:0]      cnt_q;
  logic               neg_q;
  logic [31:0]        dmag_q;
  logic [31:0]        rem_q;
  logic [NW-1:0]      num_q;
  logic signed [31:0] quo_q;

  logic [31:0] nabs, dabs;
  logic [32:0] rem_sh, diff;
  logic        take;
  logic        ovf_pos, ovf_neg;
  logic [31:0] qneg;

  assign nabs   = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign dabs   = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign rem_sh = {rem_q, num_q[NW-1]};
  assign diff   = rem_sh - {1'b0, dmag_q};
  assign take   = !diff[32];

  // num_q holds the magnitude of the quotient once the bits are done
  assign ovf_pos = |num_q[NW-1:31];
  assign ovf_neg = (|num_q[NW-1:32]) || (num_q[31] && (|num_q[30:0]));
  assign qneg    = ~num_q[31:0] + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == 32'sd0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(NW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= num_i[31] ^ den_i[31];
      dmag_q <= dabs;
      rem_q  <= '0;
      num_q  <= {nabs, {FRAC_BITS{1'b0}}};
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[31:0] : rem_sh[31:0];
      num_q <= {num_q[NW-2:0], take};
    end else if (fin_q) begin
      if (!neg_q) begin
        quo_q <= ovf_pos ? S32_MAX : num_q[31:0];
      end else begin
        quo_q <= ovf_neg ? S32_MIN : qneg;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  `SKF_ASSERT(a_div_idle_start, start_i |-> !busy_q && !fin_q, "div: start while busy")
  `SKF_ASSERT(a_div_done_pulse, done_q |=> !done_q, "div: done longer than a cycle")
  `SKF_ASSERT(a_div_zero_den, start_i && den_i == 32'sd0 |=> done_q,
              "div: zero divisor not finished at once")

endmodule

// ===== rtl/core/scalar_kalman_filter_unit.sv =====
// Channel  Dir  Payload                                     Handshake
// req_i    in   measurement, control_input, restart         valid / ready
// rsp_o    out  estimate, innovation, error_variance        valid / ready
// cfg      in   cfg_idx_i, cfg_wdata_i                      cfg_we_i, no wait
//
// A request runs as eleven multiply-adds on the one shared multiplier, with the
// restoring divider for the gain (one quotient bit per cycle, plus start and finish)
// after the eighth; then the output register is loaded and the unit returns to idle
// before it accepts the next request. req_i.ready is high only between requests.
// A finished result waits in the output register; a new request is taken meanwhile
// but completes only once it is read. Reset restores the register defaults and clears
// estimate and variance.
`include "assert_macros.svh"

module scalar_kalman_filter_unit import skf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  skf_req_if.sink              req_i,
  skf_rsp_if.source            rsp_o
);

  localparam int unsigned ACC_W = 65 - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ONE_FX = ACC_W'(1) << FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [3:0] STEP_FX = 4'd0;   // F*x
  localparam logic [3:0] STEP_XP = 4'd1;   // xp = F*x + B*u
  localparam logic [3:0] STEP_FP = 4'd2;   // F*P
  localparam logic [3:0] STEP_PP = 4'd3;   // pp = (F*P)*F + Q
  localparam logic [3:0] STEP_Y  = 4'd4;   // y = z - H*xp
  localparam logic [3:0] STEP_HP = 4'd5;   // H*pp
  localparam logic [3:0] STEP_S  = 4'd6;   // S = (H*pp)*H + R
  localparam logic [3:0] STEP_PH = 4'd7;   // pp*H, then divide
  localparam logic [3:0] STEP_X  = 4'd8;   // x = xp + K*y
  localparam logic [3:0] STEP_KH = 4'd9;   // 1 - K*H
  localparam logic [3:0] STEP_P  = 4'd10;  // P = (1-K*H)*pp

  logic [1:0] state_q;
  logic [3:0] step_q;
  logic       wait_q;
  logic       out_valid_q;

  logic signed [31:0] f_q, h_q, b_q, ie_q;
  logic        [30:0] q_q, r_q, iv_q;
  logic signed [31:0] x_q;
  logic        [30:0] p_q;

  logic signed [31:0]      z_q, u_q, xp_q, pp_q, y_q, s_q, k_q;
  logic signed [ACC_W-1:0] tmp_q;
  logic signed [31:0]      out_est_q, out_y_q;
  logic        [30:0]      out_p_q;

  mac_req_t                mac_req;
  logic signed [ACC_W-1:0] mac_add;
  logic                    mac_valid;
  logic signed [ACC_W-1:0] mac_sum;
  logic signed [31:0]      mac_sat;

  logic               div_start, div_done;
  logic signed [31:0] div_quo;

  logic acc, out_load;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  assign div_start   = mac_valid && (step_q == STEP_PH);

  always_comb begin
    mac_req.valid = (state_q == ST_MAC) && !wait_q;
    mac_req.sub   = 1'b0;
    mac_req.a     = '0;
    mac_req.b     = '0;
    mac_add       = '0;
    case (step_q)
      STEP_FX: begin
        mac_req.a = f_q;
        mac_req.b = x_q;
      end
      STEP_XP: begin
        mac_req.a = b_q;
        mac_req.b = u_q;
        mac_add   = tmp_q;
      end
      STEP_FP: begin
        mac_req.a = f_q;
        mac_req.b = {1'b0, p_q};
      end
      STEP_PP: begin
        mac_req.a = tmp_q[31:0];
        mac_req.b = f_q;
        mac_add   = ACC_W'(q_q);
      end
      STEP_Y: begin
        mac_req.a   = h_q;
        mac_req.b   = xp_q;
        mac_req.sub = 1'b1;
        mac_add     = ACC_W'(z_q);
      end
      STEP_HP: begin
        mac_req.a = h_q;
        mac_req.b = pp_q;
      end
      STEP_S: begin
        mac_req.a = tmp_q[31:0];
        mac_req.b = h_q;
        mac_add   = ACC_W'(r_q);
      end
      STEP_PH: begin
        mac_req.a = pp_q;
        mac_req.b = h_q;
      end
      STEP_X: begin
        mac_req.a = k_q;
        mac_req.b = y_q;
        mac_add   = ACC_W'(xp_q);
      end
      STEP_KH: begin
        mac_req.a   = k_q;
        mac_req.b   = h_q;
        mac_req.sub = 1'b1;
        mac_add     = ONE_FX;
      end
      STEP_P: begin
        mac_req.a = tmp_q[31:0];
        mac_req.b = pp_q;
      end
      default: begin
        mac_req.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_FX;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
      f_q         <= 32'sd65536;
      h_q         <= 32'sd65536;
      b_q         <= 32'sd66;
      q_q         <= 31'd7;
      r_q         <= 31'd6554;
      ie_q        <= '0;
      iv_q        <= '0;
      x_q         <= '0;
      p_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_F_GAIN:   f_q  <= cfg_wdata_i;
          REG_H_GAIN:   h_q  <= cfg_wdata_i;
          REG_B_GAIN:   b_q  <= cfg_wdata_i;
          REG_Q_NOISE:  q_q  <= cfg_wdata_i[30:0];
          REG_R_NOISE:  r_q  <= cfg_wdata_i[30:0];
          REG_INIT_EST: ie_q <= cfg_wdata_i;
          REG_INIT_VAR: iv_q <= cfg_wdata_i[30:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.valid && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            state_q <= ST_MAC;
            step_q  <= STEP_FX;
            wait_q  <= 1'b0;
            if (req_i.restart) begin
              x_q <= ie_q;
              p_q <= iv_q;
            end
          end
        end
        ST_MAC: begin
          if (mac_req.valid) begin
            wait_q <= 1'b1;
          end
          if (mac_valid) begin
            wait_q <= 1'b0;
            step_q <= step_q + 4'd1;
            if (step_q == STEP_PH) begin
              state_q <= ST_DIV;
            end
            if (step_q == STEP_X) begin
              x_q <= mac_sat;
            end
            if (step_q == STEP_P) begin
              // variance never goes negative
              p_q     <= mac_sat[31] ? '0 : mac_sat[30:0];
              state_q <= ST_DONE;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_MAC;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q     <= ST_IDLE;
            step_q      <= STEP_FX;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      z_q <= req_i.measurement;
      u_q <= req_i.control_input;
    end
    if (mac_valid) begin
      case (step_q)
        STEP_FX: tmp_q <= mac_sum;
        STEP_XP: xp_q  <= mac_sat;
        STEP_PP: pp_q  <= mac_sat;
        STEP_Y:  y_q   <= mac_sat;
        STEP_S:  s_q   <= mac_sat;
        STEP_FP, STEP_HP, STEP_KH: tmp_q <= ACC_W'(mac_sat);
        default: ;
      endcase
    end
    if (div_done) begin
      k_q <= div_quo;
    end
    if (out_load) begin
      out_est_q <= x_q;
      out_y_q   <= y_q;
      out_p_q   <= p_q;
    end
  end

  skf_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mac_req),
    .addend_i (mac_add),
    .valid_o  (mac_valid),
    .sum_o    (mac_sum),
    .sat_o    (mac_sat)
  );

  skf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mac_sat),
    .den_i   (s_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.estimate       = out_est_q;
  assign rsp_o.innovation     = out_y_q;
  assign rsp_o.error_variance = out_p_q;

  `SKF_ASSERT(a_one_request, acc |=> !req_i.ready, "top: second request taken while busy")
  `SKF_ASSERT(a_mac_in_seq, mac_valid |-> state_q == ST_MAC, "top: mac result out of sequence")
  `SKF_ASSERT(a_div_in_seq, div_done |-> state_q == ST_DIV, "top: quotient out of sequence")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import skf_pkg::*;

  localparam int unsigned FRAC = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam longint ONE  = 64'sd1 <<< FRAC;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 110;
  localparam int DIR_ROWS    = 46;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic signed [31:0] innovation;
    logic        [30:0] error_variance;
  } kf_out_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_e;
  typedef enum logic [1:0] {MODE_TRACK, MODE_WILD, MODE_CORNER} phase_mode_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
    logic signed [31:0]   z;
    logic signed [31:0]   u;
    logic                 restart;
    logic                 fixed_ok;
    kf_out_t              fixed;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0]          cfg_wdata_i;

  skf_req_if req_if ();
  skf_rsp_if rsp_if ();

  scalar_kalman_filter_unit #(.FRAC_BITS(FRAC)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // filter state and register copies, Q15.16 held in 64 bits
  longint gain_f = 65536, gain_h = 65536, gain_b = 66;
  longint noise_q = 7, noise_r = 6554;
  longint init_est = 0, init_var = 0;
  longint est_now = 0, var_now = 0;

  kf_out_t  pending[$];
  dir_row_t dir_tab [DIR_ROWS];

  int n_errors = 0;
  int n_results = 0;
  int n_samples = 0;
  int n_restarts = 0;
  int n_settings = 0;
  int req_gap_max = 4;
  int rsp_stall_max = 4;

  function automatic longint clamp_s32(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic kf_out_t next_filter_output(input logic signed [31:0] z,
                                                 input logic signed [31:0] u,
                                                 input logic rs);
    longint xp, pp, y, s, ph, k, kh, x, p;
    kf_out_t r;
    if (rs) begin
      est_now = init_est;
      var_now = init_var;
    end
    xp = clamp_s32(qmul(gain_f, est_now) + qmul(gain_b, longint'(u)));
    pp = clamp_s32(qmul(clamp_s32(qmul(gain_f, var_now)), gain_f) + noise_q);
    y  = clamp_s32(longint'(z) - qmul(gain_h, xp));
    s  = clamp_s32(qmul(clamp_s32(qmul(gain_h, pp)), gain_h) + noise_r);
    ph = clamp_s32(qmul(pp, gain_h));
    k  = (s == 0) ? 64'sd0 : clamp_s32((ph * ONE) / s);
    x  = clamp_s32(xp + qmul(k, y));
    kh = clamp_s32(ONE - qmul(k, gain_h));
    p  = clamp_s32(qmul(kh, pp));
    if (p < 0) p = 0;
    est_now = x;
    var_now = p;
    r.estimate       = x[31:0];
    r.innovation     = y[31:0];
    r.error_variance = p[30:0];
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic dir_row_t req_row(input logic signed [31:0] z, input logic signed [31:0] u,
                                       input logic rs);
    dir_row_t r;
    r         = '0;
    r.kind    = ROW_REQ;
    r.z       = z;
    r.u       = u;
    r.restart = rs;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic signed [31:0] z, input logic signed [31:0] u,
                                       input logic rs, input logic signed [31:0] x,
                                       input logic signed [31:0] y, input logic [30:0] p);
    dir_row_t r;
    r                      = req_row(z, u, rs);
    r.fixed_ok             = 1'b1;
    r.fixed.estimate       = x;
    r.fixed.innovation     = y;
    r.fixed.error_variance = p;
    return r;
  endfunction

  function automatic logic signed [31:0] corner_value();
    case ($urandom_range(0, 5))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // drop valid and let every outstanding request complete
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_F_GAIN:   gain_f   = longint'($signed(data));
      REG_H_GAIN:   gain_h   = longint'($signed(data));
      REG_B_GAIN:   gain_b   = longint'($signed(data));
      REG_Q_NOISE:  noise_q  = longint'(data[30:0]);
      REG_R_NOISE:  noise_r  = longint'(data[30:0]);
      REG_INIT_EST: init_est = longint'($signed(data));
      REG_INIT_VAR: init_var = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic signed [31:0] z, input logic signed [31:0] u,
                             input logic rs, input logic use_fixed, input kf_out_t fixed);
    int gap;
    kf_out_t want;
    gap = $urandom_range(0, req_gap_max);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.measurement   <= z;
    req_if.control_input <= u;
    req_if.restart       <= rs;
    @(posedge clk_i);
    while (!(req_if.valid && req_if.ready)) @(posedge clk_i);
    want = next_filter_output(z, u, rs);
    pending.push_back(use_fixed ? fixed : want);
    n_samples++;
    if (rs) n_restarts++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $error("timeout: %0d results still outstanding", pending.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : result_monitor
    kf_out_t want;
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rsp_stall_max);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk_i);
      n_results++;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        want = pending.pop_front();
        if (rsp_if.estimate !== want.estimate) begin
          $error("estimate: expected %0d, got %0d", want.estimate, rsp_if.estimate);
          n_errors++;
        end
        if (rsp_if.innovation !== want.innovation) begin
          $error("innovation: expected %0d, got %0d", want.innovation, rsp_if.innovation);
          n_errors++;
        end
        if (rsp_if.error_variance !== want.error_variance) begin
          $error("error_variance: expected %0d, got %0d", want.error_variance,
                 rsp_if.error_variance);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    phase_mode_e mode;
    int trend;
    logic signed [31:0] z, u;
    logic rs;
    bit hi;

    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_wdata_i          <= '0;
    req_if.valid         <= 1'b0;
    req_if.measurement   <= '0;
    req_if.control_input <= '0;
    req_if.restart       <= 1'b0;

    dir_tab = '{
      chk_row(0, 0, 1'b0, 0, 0, 6),                          // defaults after reset
      req_row(32'sd65536, 0, 1'b0),
      req_row(-32'sd65536, 32'sd65536, 1'b0),
      req_row(32'sh0012_3456, -32'sd1000, 1'b0),
      cfg_row(REG_F_GAIN, 32'd0),
      cfg_row(REG_H_GAIN, 32'd0),
      cfg_row(REG_B_GAIN, 32'd0),
      cfg_row(REG_Q_NOISE, 32'd0),
      cfg_row(REG_R_NOISE, 32'd0),
      chk_row(S32_MAX, S32_MAX, 1'b1, 0, S32_MAX, 0),        // S = 0 gives K = 0
      chk_row(S32_MIN, S32_MIN, 1'b0, 0, S32_MIN, 0),
      cfg_row(REG_F_GAIN, 32'd65536),
      cfg_row(REG_H_GAIN, 32'd65536),
      cfg_row(REG_INIT_EST, S32_MAX),
      chk_row(S32_MIN, 0, 1'b1, S32_MAX, S32_MIN, 0),        // residual clamps low
      chk_row(S32_MAX, S32_MAX, 1'b0, S32_MAX, 0, 0),
      cfg_row(REG_B_GAIN, S32_MAX),
      chk_row(0, S32_MAX, 1'b0, S32_MAX, -S32_MAX, 0),       // predicted x clamps high
      cfg_row(REG_B_GAIN, S32_MIN),
      chk_row(0, S32_MAX, 1'b0, S32_MIN, S32_MAX, 0),        // predicted x clamps low
      cfg_row(REG_B_GAIN, 32'd0),
      cfg_row(REG_H_GAIN, 32'h0100_0000),
      cfg_row(REG_INIT_EST, 32'd0),
      cfg_row(REG_INIT_VAR, 32'h0100_0000),
      req_row(0, 0, 1'b1),                                    // K*H above one, P clamps to 0
      req_row(32'sd65536, 0, 1'b0),
      cfg_row(REG_Q_NOISE, 32'hFFFF_FFFF),                    // top bit is dropped
      cfg_row(REG_R_NOISE, 32'hFFFF_FFFF),
      req_row(32'sd65536, -32'sd65536, 1'b0),
      cfg_row(REG_INIT_VAR, 32'hFFFF_FFFF),
      cfg_row(REG_F_GAIN, S32_MIN),
      req_row(S32_MAX, S32_MIN, 1'b1),
      cfg_row(REG_F_GAIN, S32_MAX),
      cfg_row(REG_H_GAIN, S32_MIN),
      req_row(S32_MIN, S32_MAX, 1'b1),
      cfg_row(REG_UNUSED, 32'hFFFF_FFFF),                     // no such register
      req_row(32'sd12345, -32'sd54321, 1'b0),
      cfg_row(REG_F_GAIN, 32'd65536),
      cfg_row(REG_H_GAIN, 32'd65536),
      cfg_row(REG_B_GAIN, 32'd66),
      cfg_row(REG_Q_NOISE, 32'd7),
      cfg_row(REG_R_NOISE, 32'd6554),
      cfg_row(REG_INIT_EST, 32'd0),
      cfg_row(REG_INIT_VAR, 32'd0),
      chk_row(0, 0, 1'b1, 0, 0, 6),                          // restart matches reset
      req_row(-32'sd100000, 32'sd3000, 1'b0)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].wdata);
      end else begin
        send_sample(dir_tab[i].z, dir_tab[i].u, dir_tab[i].restart, dir_tab[i].fixed_ok,
                    dir_tab[i].fixed);
      end
    end

    trend = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode = (ph % 5 == 1) ? MODE_WILD : (ph % 5 == 3) ? MODE_CORNER : MODE_TRACK;
      case (ph % 4)
        0: begin
          req_gap_max = 4;
          rsp_stall_max = 4;
        end
        1: begin
          req_gap_max = 0;
          rsp_stall_max = 0;
        end
        2: begin
          req_gap_max = 4;
          rsp_stall_max = 0;
        end
        default: begin
          req_gap_max = 0;
          rsp_stall_max = 4;
        end
      endcase

      case (mode)
        MODE_TRACK: begin
          write_reg(REG_F_GAIN, 32'(58982 + $urandom_range(0, 13108)));
          write_reg(REG_H_GAIN, 32'(32768 + $urandom_range(0, 98304)));
          write_reg(REG_B_GAIN, 32'(int'($urandom_range(0, 131072)) - 65536));
          write_reg(REG_Q_NOISE, 32'($urandom_range(0, 65536)));
          write_reg(REG_R_NOISE, 32'($urandom_range(0, 262144)));
          trend = int'($urandom_range(0, 8388608)) - 4194304;
          write_reg(REG_INIT_EST, 32'(trend));
          write_reg(REG_INIT_VAR, 32'($urandom_range(0, 1048576)));
        end
        MODE_WILD: begin
          write_reg(REG_F_GAIN, $urandom());
          write_reg(REG_H_GAIN, $urandom());
          write_reg(REG_B_GAIN, $urandom());
          write_reg(REG_Q_NOISE, $urandom());
          write_reg(REG_R_NOISE, $urandom());
          write_reg(REG_INIT_EST, $urandom());
          write_reg(REG_INIT_VAR, $urandom());
          write_reg(REG_UNUSED, $urandom());
        end
        default: begin
          hi = (ph < 5);
          write_reg(REG_F_GAIN, hi ? S32_MAX : S32_MIN);
          write_reg(REG_H_GAIN, hi ? S32_MAX : S32_MIN);
          write_reg(REG_B_GAIN, hi ? S32_MAX : S32_MIN);
          write_reg(REG_Q_NOISE, hi ? 32'hFFFF_FFFF : 32'h0);
          write_reg(REG_R_NOISE, hi ? 32'hFFFF_FFFF : 32'h0);
          write_reg(REG_INIT_EST, hi ? S32_MAX : S32_MIN);
          write_reg(REG_INIT_VAR, hi ? 32'hFFFF_FFFF : 32'h0);
        end
      endcase
      n_settings++;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then hold off until the filter has drained
        if ($urandom_range(0, 63) == 0) wait_idle();
        case (mode)
          MODE_TRACK: begin
            if ($urandom_range(0, 9) != 0) begin
              trend = trend + int'($urandom_range(0, 2048)) - 1024;
              z = trend + int'($urandom_range(0, 131072)) - 65536;
              u = int'($urandom_range(0, 131072)) - 65536;
              rs = ($urandom_range(0, 29) == 0);
            end else begin
              z = $urandom();
              u = $urandom();
              rs = 1'($urandom_range(0, 1));
            end
          end
          MODE_WILD: begin
            z = $urandom();
            u = $urandom();
            rs = ($urandom_range(0, 3) == 0);
          end
          default: begin
            z = corner_value();
            u = corner_value();
            rs = ($urandom_range(0, 3) == 0);
          end
        endcase
        send_sample(z, u, rs, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);

    $display("%0d samples sent (%0d with restart), %0d results checked, %0d setting phases",
             n_samples, n_restarts, n_results, n_settings);
    $display("covered: reset defaults, zero divisor, clamping at both ends, negative variance");
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/skf_pkg.sv
rtl/core/skf_req_if.sv
rtl/core/skf_rsp_if.sv
rtl/core/skf_mac.sv
rtl/core/skf_div.sv
rtl/core/scalar_kalman_filter_unit.sv
tb/sv/tb_top.sv
